FILE: sv/pcg32_random_generator_macros.svh
// Assertion helpers used by the checker file.
`ifndef PCG32_RANDOM_GENERATOR_MACROS_SVH
`define PCG32_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define PCG32_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcg32: same-cycle check failed");

// Next-cycle implication, reset masks the check.
`define PCG32_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcg32: next-cycle check failed");

`endif

FILE: sv/pcg32_pkg.sv
package pcg32_pkg;

	localparam int unsigned KIND_W      = 3;
	localparam int unsigned BOUND_W     = 32;
	localparam int unsigned VALUE_W     = 53;
	localparam int unsigned OUT_TDATA_W = 56;

	localparam logic [KIND_W-1:0] KIND_RAW     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BOUNDED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FRAC24  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FRAC53  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RESEED  = 3'd4;

	localparam int unsigned REG_SEED   = 0;
	localparam int unsigned REG_STREAM = 1;

	localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
	// State left by the seeding sequence with zero seed and stream zero: LCG_MULT + 1.
	localparam logic [63:0] STATE_RESET = 64'h5851_F42D_4C95_7F2E;
	localparam logic [63:0] INC_RESET   = 64'd1;

	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_LO,
		MOP_X1,
		MOP_X2,
		MOP_INC,
		MOP_BND
	} mop_t;

	typedef enum logic [2:0] {
		OSEL_ZERO,
		OSEL_R,
		OSEL_R8,
		OSEL_AB,
		OSEL_M
	} osel_t;

	typedef struct packed {
		logic  accept;
		logic  reseed_init;
		logic  seed_add;
		mop_t  mop;
		logic  a_load;
		logic  div_start;
		logic  div_step;
		logic  out_load;
		osel_t osel;
		logic  out_bad;
	} cmd_t;

	typedef struct packed {
		logic bound_zero;
		logic l_lt_bound;
		logic l_lt_thr;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

FILE: sv/pcg32_ctrl.sv
module pcg32_ctrl import pcg32_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] in_kind,
	input  stat_t             st,
	output cmd_t              cmd
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ZCHK = 11'b000_0000_0010,
		ST_MLO  = 11'b000_0000_0100,
		ST_MX1  = 11'b000_0000_1000,
		ST_MX2  = 11'b000_0001_0000,
		ST_MINC = 11'b000_0010_0000,
		ST_SEED = 11'b000_0100_0000,
		ST_BMUL = 11'b000_1000_0000,
		ST_BCHK = 11'b001_0000_0000,
		ST_DIV  = 11'b010_0000_0000,
		ST_FIN  = 11'b100_0000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [KIND_W-1:0] kind_q, kind_d;
	logic              second_q, second_d;
	logic              thr_q, thr_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d         = state_q;
		kind_d          = kind_q;
		second_d        = second_q;
		thr_d           = thr_q;
		cmd.accept      = 1'b0;
		cmd.reseed_init = 1'b0;
		cmd.seed_add    = 1'b0;
		cmd.mop         = MOP_NONE;
		cmd.a_load      = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.div_step    = 1'b0;
		cmd.out_load    = 1'b0;
		cmd.osel        = OSEL_ZERO;
		cmd.out_bad     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					kind_d     = in_kind;
					second_d   = 1'b0;
					thr_d      = 1'b0;
					case (in_kind)
						KIND_RAW, KIND_FRAC24, KIND_FRAC53: state_d = ST_MLO;
						KIND_BOUNDED: state_d = ST_ZCHK;
						KIND_RESEED: begin
							cmd.reseed_init = 1'b1;
							state_d         = ST_MLO;
						end
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_ZCHK: state_d = st.bound_zero ? ST_FIN : ST_MLO;
			ST_MLO: begin
				cmd.mop = MOP_LO;
				state_d = ST_MX1;
			end
			ST_MX1: begin
				cmd.mop = MOP_X1;
				state_d = ST_MX2;
			end
			ST_MX2: begin
				cmd.mop = MOP_X2;
				state_d = ST_MINC;
			end
			ST_MINC: begin
				cmd.mop = MOP_INC;
				case (kind_q)
					KIND_FRAC53: begin
						if (!second_q) begin
							// keep the high half, draw again for the low half
							cmd.a_load = 1'b1;
							second_d   = 1'b1;
							state_d    = ST_MLO;
						end else begin
							state_d = ST_FIN;
						end
					end
					KIND_BOUNDED: state_d = ST_BMUL;
					KIND_RESEED: state_d = second_q ? ST_FIN : ST_SEED;
					default: state_d = ST_FIN;
				endcase
			end
			ST_SEED: begin
				cmd.seed_add = 1'b1;
				second_d     = 1'b1;
				state_d      = ST_MLO;
			end
			ST_BMUL: begin
				cmd.mop = MOP_BND;
				state_d = ST_BCHK;
			end
			ST_BCHK: begin
				if (thr_q) begin
					state_d = st.l_lt_thr ? ST_MLO : ST_FIN;
				end else if (st.l_lt_bound) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					thr_d   = 1'b1;
					state_d = ST_BCHK;
				end
			end
			ST_FIN: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
					case (kind_q)
						KIND_RAW: cmd.osel = OSEL_R;
						KIND_FRAC24: cmd.osel = OSEL_R8;
						KIND_FRAC53: cmd.osel = OSEL_AB;
						KIND_BOUNDED: begin
							cmd.osel    = st.bound_zero ? OSEL_ZERO : OSEL_M;
							cmd.out_bad = st.bound_zero;
						end
						default: cmd.osel = OSEL_ZERO;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= KIND_RAW;
			second_q <= 1'b0;
			thr_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			second_q <= second_d;
			thr_q    <= thr_d;
		end
	end

endmodule

FILE: sv/pcg32_dp.sv
module pcg32_dp import pcg32_pkg::*; #(
	parameter int unsigned CFG_INDEX_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data,
	input  logic [BOUND_W-1:0]     in_bound,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [VALUE_W-1:0]     out_value,
	output logic                   out_bad,
	input  cmd_t                   cmd,
	output stat_t                  st
);

	logic [63:0]        seed_q, stream_q;
	logic [63:0]        state_q, inc_q;
	logic [63:0]        acc_q;
	logic [31:0]        r_q;
	logic [26:0]        a_q;
	logic [BOUND_W-1:0] bound_q;
	logic [31:0]        rem_q, num_q;
	logic [4:0]         cnt_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_bad_q;

	logic [31:0]        mul_a, mul_b;
	logic [63:0]        prod;
	logic [31:0]        perm;
	logic [32:0]        trial;
	logic [VALUE_W-1:0] out_sel;

	// XSH-RR output of a 64-bit state: xorshift high, rotate right by the top five bits
	function automatic logic [31:0] xsh_rr(input logic [63:0] s);
		logic [63:0] x;
		logic [31:0] xs;
		logic [63:0] dbl;
		x   = s ^ (s >> 18);
		xs  = x[58:27];
		dbl = {xs, xs} >> s[63:59];
		return dbl[31:0];
	endfunction

	assign perm = xsh_rr(state_q);

	always_comb begin
		mul_a = state_q[31:0];
		mul_b = LCG_MULT[31:0];
		case (cmd.mop)
			MOP_X1: mul_b = LCG_MULT[63:32];
			MOP_X2: mul_a = state_q[63:32];
			MOP_BND: begin
				mul_a = r_q;
				mul_b = bound_q;
			end
			default: ;
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign trial = {rem_q, num_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= 64'd0;
			stream_q <= 64'd0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_INDEX_W'(REG_SEED)) seed_q <= cfg_data;
			if (cfg_index == CFG_INDEX_W'(REG_STREAM)) stream_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			inc_q   <= INC_RESET;
		end else begin
			if (cmd.reseed_init) begin
				inc_q   <= {stream_q[62:0], 1'b1};
				state_q <= 64'd0;
			end else if (cmd.seed_add) begin
				state_q <= state_q + seed_q;
			end else if (cmd.mop == MOP_INC) begin
				state_q <= acc_q + inc_q;
			end
		end
	end

	// low 64 bits of state * multiplier in three passes, then the bound product
	always_ff @(posedge clk) begin
		case (cmd.mop)
			MOP_LO, MOP_BND: acc_q <= prod;
			MOP_X1, MOP_X2: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			MOP_INC: r_q <= perm;
			default: ;
		endcase
		if (cmd.a_load) a_q <= perm[31:5];
		if (cmd.accept) bound_q <= in_bound;
	end

	// remainder of (2^32 - bound) by bound, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= 32'd0;
			num_q <= 32'd0 - bound_q;
			cnt_q <= 5'd0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[30:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
			if (trial >= {1'b0, bound_q}) begin
				rem_q <= 32'(trial - {1'b0, bound_q});
			end else begin
				rem_q <= trial[31:0];
			end
		end
	end

	always_comb begin
		case (cmd.osel)
			OSEL_R: out_sel = VALUE_W'(r_q);
			OSEL_R8: out_sel = VALUE_W'(r_q[31:8]);
			OSEL_AB: out_sel = {a_q, r_q[31:6]};
			OSEL_M: out_sel = VALUE_W'(acc_q[63:32]);
			default: out_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= out_sel;
			out_bad_q   <= cmd.out_bad;
		end
	end

	assign st.bound_zero = (bound_q == '0);
	assign st.l_lt_bound = (acc_q[31:0] < bound_q);
	assign st.l_lt_thr   = (acc_q[31:0] < rem_q);
	assign st.div_last   = (cnt_q == 5'd31);
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_bad   = out_bad_q;

endmodule

FILE: sv/pcg32_random_generator.sv
// PCG32 (XSH-RR) generator with a 64-bit LCG state and raw, bounded (Lemire, with
// rejection), 24-bit fraction, 53-bit fraction and reseed requests; every request
// gives one result item. Requests are taken one at a time. Each draw runs on one
// shared 32x32 multiplier (three partial products of the 64-bit LCG product, then
// the increment add). Fraction53 takes two draws, reseed two state steps around the
// seed add, and a zero bound skips the draw. A bounded draw computes the threshold
// remainder bit-serially and rechecks when the first low word falls below the
// bound, and redraws after every rejection. Register writes are stored only; they
// reach the state at the next reseed request. After reset the state is the one
// seeded from zero seed and stream zero.
module pcg32_random_generator import pcg32_pkg::*; #(
	parameter int unsigned CFG_INDEX_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BOUND_W-1:0]     s_tdata,   // [31:0] upper_bound
	input  logic [KIND_W-1:0]      s_tuser,   // [2:0] kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [52:0] value, [55:53] zero
	output logic                   m_tuser,   // [0] bad_bound
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data
);

	cmd_t               cmd;
	stat_t              st;
	logic [VALUE_W-1:0] value;

	assign cfg_ready = 1'b1;

	pcg32_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	pcg32_dp #(
		.CFG_INDEX_W (CFG_INDEX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_bound  (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (value),
		.out_bad   (m_tuser),
		.cmd       (cmd),
		.st        (st)
	);

	assign m_tdata = {{(OUT_TDATA_W - VALUE_W){1'b0}}, value};

endmodule

FILE: sv/pcg32_checker.sv
`include "pcg32_random_generator_macros.svh"

module pcg32_checker import pcg32_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	// a waiting result holds
	`PCG32_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// one request at a time: no accept in the cycle after an accept
	`PCG32_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a zero-bound error carries a zero value
	`PCG32_ASSERT_NOW(a_bad_is_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)

	// padding above the value stays clear
	`PCG32_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid,
		m_tdata[OUT_TDATA_W-1:VALUE_W] == '0)

endmodule

bind pcg32_random_generator pcg32_checker u_pcg32_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
